/* rtl/sequence_replay_window_unit_assert.svh */
// Assertion macros for the checker of the replay window unit.
`ifndef SEQUENCE_REPLAY_WINDOW_UNIT_ASSERT_SVH
`define SEQUENCE_REPLAY_WINDOW_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SRW_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("replay window check failed");

// Next-cycle implication, disabled while reset is high.
`define SRW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("replay window check failed");

`endif

/* rtl/srw_pkg.sv */
// Types, constants and codes of the sequence replay window unit.
package srw_pkg;

   localparam int SEQ_BITS        = 15;
   localparam int SEQ_IN_W        = 16;
   localparam int NEXT_EXP_W      = 15;
   localparam int START_SEQ_W     = 15;
   localparam int WINDOW_BITS_DEF = 32;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_WINDOW = 2'd2,
      ST_DUP    = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_SLIDE
   } srw_state_type;

   typedef struct packed {
      logic [SEQ_IN_W-1:0] seq_in;
   } req_payload_type;

   typedef struct packed {
      logic                  accepted;
      status_type            status;
      logic [NEXT_EXP_W-1:0] next_expected;
   } rsp_payload_type;

   typedef struct packed {
      logic [START_SEQ_W-1:0] start_seq;
   } csr_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic check_en;
      logic commit_en;
      logic cfg_wr;
   } srw_cmd_type;

endpackage

/* rtl/srw_chan_if.sv */
// Valid/ready channel interface carrying one payload struct.
interface srw_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/sequence_replay_window_unit.sv */
// Top level of the sequence replay window unit: anti-replay filter on wrapping numbers.
//
//   channel   direction  payload                              handshake
//   req_chan  in         seq_in                               valid/ready
//   rsp_chan  out        accepted, status, next_expected      valid/ready
//   csr_chan  in         start_seq                            valid/ready
//
// A request is first checked for range, window and duplicate; then the window
// slides past its leading set bits and the response register is loaded. The next
// request is taken in the cycle after the commit.
// A response that is not taken holds the slide step until the output
// register frees up. Reset clears the expected number and the bitmap.
// A start_seq write loads the expected number and clears the bitmap.
module sequence_replay_window_unit #(
   parameter int WINDOW_BITS = srw_pkg::WINDOW_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   srw_chan_if.sink          req_chan,
   srw_chan_if.source        rsp_chan,
   srw_chan_if.sink          csr_chan
);
   import srw_pkg::*;

   srw_cmd_type     cmd;
   rsp_payload_type rsp_payload;

   srw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_chan.ready),
      .cmd       (cmd)
   );

   srw_datapath #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_chan.payload),
      .csr_payload (csr_chan.payload),
      .rsp_payload (rsp_payload)
   );

   assign rsp_chan.payload = rsp_payload;

endmodule

/* rtl/srw_ctrl.sv */
// Controller state machine: request acceptance, commit timing, response valid.
module srw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                csr_valid,
   output logic                csr_ready,
   output srw_pkg::srw_cmd_type cmd
);
   import srw_pkg::*;

   srw_state_type state_ff;
   srw_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free      = ~rsp_valid_ff | rsp_ready;
      state_in      = state_ff;
      req_ready     = 1'b0;
      csr_ready     = ~reset;
      cmd.check_en  = 1'b0;
      cmd.commit_en = 1'b0;
      cmd.cfg_wr    = csr_valid & ~reset;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready    = ~reset;
            cmd.check_en = req_valid & ~reset;
            if (req_valid & ~reset) begin
               state_in = S_SLIDE;
            end
         end
         S_SLIDE: begin
            // The result waits here until the output register can take it.
            if (out_free) begin
               cmd.commit_en = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/srw_datapath.sv */
// Datapath: window check, bitmap update, slide and response register.
module srw_datapath #(
   parameter int WINDOW_BITS = srw_pkg::WINDOW_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  srw_pkg::srw_cmd_type    cmd,
   input  srw_pkg::req_payload_type req_payload,
   input  srw_pkg::csr_payload_type csr_payload,
   output srw_pkg::rsp_payload_type rsp_payload
);
   import srw_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_BITS);
   localparam int CNT_W = $clog2(WINDOW_BITS + 1);

   logic [SEQ_BITS-1:0]    exp_ff;
   logic [WINDOW_BITS-1:0] bm_ff;
   logic [WINDOW_BITS-1:0] cand_ff;
   status_type             status_ff;
   rsp_payload_type        rsp_ff;

   logic                   range_bad;
   logic                   win_bad;
   logic                   dup;
   logic [SEQ_BITS-1:0]    seq_gap;
   logic [IDX_W-1:0]       idx;
   logic [WINDOW_BITS-1:0] onehot;
   status_type             status_in;
   logic [CNT_W-1:0]       lead_cnt;
   logic [WINDOW_BITS-1:0] slid_bm;
   logic [SEQ_BITS-1:0]    exp_adv;
   logic                   ok;

   // Check of a new request against the current window.
   always_comb begin
      range_bad = (req_payload.seq_in >> SEQ_BITS) != '0;
      seq_gap   = req_payload.seq_in[SEQ_BITS-1:0] - exp_ff;
      win_bad   = 32'(seq_gap) >= 32'(WINDOW_BITS);
      idx       = seq_gap[IDX_W-1:0];
      onehot    = WINDOW_BITS'(1) << idx;
      dup       = |(bm_ff & onehot);
      if (range_bad) begin
         status_in = ST_RANGE;
      end else if (win_bad) begin
         status_in = ST_WINDOW;
      end else if (dup) begin
         status_in = ST_DUP;
      end else begin
         status_in = ST_OK;
      end
   end

   // Count of set bits at the bottom of the updated bitmap: the slide distance.
   always_comb begin
      lead_cnt = CNT_W'(WINDOW_BITS);
      for (int i = WINDOW_BITS - 1; i >= 0; i--) begin
         if (!cand_ff[i]) begin
            lead_cnt = CNT_W'(i);
         end
      end
      slid_bm = cand_ff >> lead_cnt;
      exp_adv = exp_ff + SEQ_BITS'(lead_cnt);
      ok      = status_ff == ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= '0;
         bm_ff  <= '0;
      end else if (cmd.cfg_wr) begin
         exp_ff <= csr_payload.start_seq[SEQ_BITS-1:0];
         bm_ff  <= '0;
      end else if (cmd.commit_en && ok) begin
         exp_ff <= exp_adv;
         bm_ff  <= slid_bm;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check_en) begin
         status_ff <= status_in;
         cand_ff   <= bm_ff | onehot;
      end
      if (cmd.commit_en) begin
         rsp_ff.accepted      <= ok;
         rsp_ff.status        <= status_ff;
         rsp_ff.next_expected <= ok ? NEXT_EXP_W'(exp_adv) : NEXT_EXP_W'(exp_ff);
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

/* rtl/srw_checker.sv */
// Port-level checker of the replay window unit and its bind to the top level.
`include "sequence_replay_window_unit_assert.svh"

module srw_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input srw_pkg::rsp_payload_type rsp_payload
);
   import srw_pkg::*;

   // A stalled response keeps its contents.
   `SRW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   // The accepted flag agrees with the status code.
   `SRW_ASSERT_IMPL(a_acc_status, clock, reset, rsp_valid, rsp_payload.accepted == (rsp_payload.status == ST_OK))
   // Two requests are never taken back to back.
   `SRW_ASSERT_NEXT(a_req_spacing, clock, reset, req_valid && req_ready, !(req_valid && req_ready))
   // A rise of the response valid is preceded by a taken request.
   `SRW_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))

endmodule

bind sequence_replay_window_unit srw_checker u_srw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

/* tb/srw_checker.sv */
// Checker for the replay window unit: predicts each response and compares it with the block.
`timescale 1ns / 1ps

module srw_monitor (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  srw_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  srw_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  srw_pkg::csr_payload_type csr_payload,
   output int                       failures,
   output int                       pending
);
   import srw_pkg::*;

   localparam int WINDOW = WINDOW_BITS_DEF;

   logic [START_SEQ_W-1:0] start_reg;
   logic [SEQ_BITS-1:0]    exp_seq;
   logic [WINDOW-1:0]      seen_map;
   rsp_payload_type        verdict_q[$];

   // Classifies one received number and updates the window as the block should.
   function automatic rsp_payload_type judge_sequence(input logic [SEQ_IN_W-1:0] seq);
      rsp_payload_type r;
      logic [SEQ_BITS-1:0] seq_gap;
      int n;
      r.accepted = 1'b0;
      if (seq[SEQ_IN_W-1]) begin
         r.status = ST_RANGE;
      end else begin
         seq_gap = seq[SEQ_BITS-1:0] - exp_seq;
         if (seq_gap >= WINDOW) begin
            r.status = ST_WINDOW;
         end else if (seen_map[seq_gap]) begin
            r.status = ST_DUP;
         end else begin
            seen_map[seq_gap] = 1'b1;
            // Slide past every leading number already seen.
            n = 0;
            while (n < WINDOW && seen_map[0]) begin
               exp_seq = exp_seq + 1'b1;
               seen_map = seen_map >> 1;
               n++;
            end
            r.accepted = 1'b1;
            r.status = ST_OK;
         end
      end
      r.next_expected = exp_seq;
      return r;
   endfunction

   initial begin
      failures = 0;
      pending = 0;
      start_reg = '0;
      exp_seq = '0;
      seen_map = '0;
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         start_reg = '0;
         exp_seq = '0;
         seen_map = '0;
         verdict_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: response with none outstanding: accepted %0d status %0d next %h",
                        $time, rsp_payload.accepted, rsp_payload.status,
                        rsp_payload.next_expected);
               failures++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_payload.accepted !== want.accepted) begin
                  $display("%0t: accepted mismatch: expected %0d, actual %0d",
                           $time, want.accepted, rsp_payload.accepted);
                  failures++;
               end
               if (rsp_payload.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_payload.status);
                  failures++;
               end
               if (rsp_payload.next_expected !== want.next_expected) begin
                  $display("%0t: next_expected mismatch: expected %h, actual %h",
                           $time, want.next_expected, rsp_payload.next_expected);
                  failures++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            start_reg = csr_payload.start_seq;
            exp_seq = start_reg;
            seen_map = '0;
         end
         if (req_valid && req_ready)
            verdict_q.push_back(judge_sequence(req_payload.seq_in));
      end
      pending = verdict_q.size();
   end

endmodule

/* tb/testbench.sv */
// Top of the replay window testbench: clock, reset, request and setting stimulus, verdict.
`timescale 1ns / 1ps

module testbench;
   import srw_pkg::*;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   bit   hold_off_request;
   bit   no_idle;

   srw_chan_if #(.payload_type(req_payload_type)) req_chan ();
   srw_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();
   srw_chan_if #(.payload_type(csr_payload_type)) csr_chan ();

   sequence_replay_window_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   srw_monitor checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload),
      .csr_valid   (csr_chan.valid),
      .csr_ready   (csr_chan.ready),
      .csr_payload (csr_chan.payload),
      .failures    (failures),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[sequence_replay_window_unit] ERROR");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (no_idle || r < 12)
         return 0;
      else if (r < 18)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Response side: random stalls, plus one long hold-off when asked.
   initial begin
      int gap_left;
      int hold_left;
      gap_left = 0;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = 400;
            rsp_chan.ready <= 1'b0;
         end else if (gap_left > 0 && !no_idle) begin
            rsp_chan.ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            gap_left = 0;
            if ($urandom_range(0, 3) == 0)
               gap_left = pick_gap();
         end
      end
   end

   task automatic push_request(input logic [SEQ_IN_W-1:0] seq);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= seq;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   // New session; only issued once every response is back.
   task automatic load_start(input logic [START_SEQ_W-1:0] value);
      release_request();
      wait (pending == 0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.payload <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // One session: the stream arrives in shuffled blocks, with duplicates and stray numbers.
   // mode 1 holds off the receiver, mode 2 pauses the sender midway, mode 3 runs without gaps.
   task automatic run_session(input logic [START_SEQ_W-1:0] start, input int count,
                              input int mode);
      logic [SEQ_BITS-1:0] block[32];
      logic [SEQ_BITS-1:0] base;
      logic [SEQ_BITS-1:0] tmp;
      int sent;
      int sz;
      int j;
      int r;
      bit paused;
      load_start(start);
      base = start;
      sent = 0;
      paused = 1'b0;
      no_idle = (mode == 3);
      if (mode == 1)
         hold_off_request = 1'b1;
      while (sent < count) begin
         sz = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 12);
         for (int i = 0; i < sz; i++)
            block[i] = base + SEQ_BITS'(i);
         for (int i = sz - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = block[i];
            block[i] = block[j];
            block[j] = tmp;
         end
         for (int i = 0; i < sz; i++) begin
            r = $urandom_range(0, 39);
            if (r == 0)
               push_request(SEQ_IN_W'($urandom_range(16'h8000, 16'hFFFF)));
            else if (r == 1)
               push_request(SEQ_IN_W'($urandom_range(0, 16'h7FFF)));
            else if (r == 2)
               push_request({1'b0, base + SEQ_BITS'(WINDOW_BITS_DEF + $urandom_range(0, 3))});
            else if (r < 7 && i > 0)
               push_request({1'b0, block[$urandom_range(0, i - 1)]});
            if (r < 7)
               sent++;
            push_request({1'b0, block[i]});
            sent++;
            if (mode == 2 && !paused && sent >= count / 2) begin
               paused = 1'b1;
               release_request();
               wait (pending == 0);
               repeat ($urandom_range(5, 30)) @(posedge clock);
            end
         end
         base = base + SEQ_BITS'(sz);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      hold_off_request = 1'b0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      csr_chan.valid = 1'b0;
      csr_chan.payload = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part around the wrap of the sequence space.
      load_start(15'h7FFE);
      push_request(16'hFFFF);          // out of range, all ones
      push_request(16'h8000);          // lowest out-of-range number
      push_request(16'h7FFE);          // the expected number itself
      push_request(16'h7FFE);          // now behind the window
      push_request(16'h0001);          // ahead across the wrap
      push_request(16'h0001);          // duplicate
      push_request(16'h0000);
      push_request(16'h7FFF);          // fills the gap, slides to 2
      push_request(16'd33);            // last slot of the window
      push_request(16'd34);            // one past the window
      push_request(16'h0000);          // far behind
      push_request(16'd2);
      push_request(16'd33);            // duplicate, one below the top slot
      load_start(15'h0000);
      push_request(16'h0000);
      push_request(16'h7FFF);
      push_request(16'd31);
      push_request(16'd32);
      push_request(16'h5555);
      push_request(16'hAAAA);

      run_session(15'h7FFF, 200, 0);
      run_session(15'h0000, 200, 1);
      run_session(15'h7FE0, 200, 2);
      run_session(15'($urandom), 200, 3);
      run_session(15'($urandom), 200, 0);
      run_session(15'h0001, 200, 0);
      run_session(15'h2AAA, 200, 0);
      run_session(15'h5555, 200, 2);
      run_session(15'($urandom), 200, 0);

      release_request();
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("[sequence_replay_window_unit] OK");
      else
         $display("[sequence_replay_window_unit] ERROR");
      $finish;
   end

endmodule
